// File: rtl/core/b64d_pkg.sv
// Package for the delimited base64url word decoder.
// Holds item, queue and status types plus the character map; no dependencies.
package b64d_pkg;

  // Character codes used by the digit map
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  // Digit offsets of each character range
  localparam logic [5:0] DIG_LOWER_BASE = 6'd26;
  localparam logic [5:0] DIG_NUM_BASE   = 6'd52;
  localparam logic [5:0] DIG_DASH       = 6'd62;
  localparam logic [5:0] DIG_UNDER      = 6'd63;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    KIND_WIDTH  = 2'd0,
    KIND_HEIGHT = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_END    = 2'd3
  } word_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  // How many header words have been taken so far
  typedef enum logic [1:0] {
    WS_WIDTH  = 2'd0,
    WS_HEIGHT = 2'd1,
    WS_PIXELS = 2'd2
  } words_seen_t;

  typedef enum logic [1:0] {
    B_CHAR,
    B_FINISH,
    B_WAIT,
    B_STATUS
  } back_state_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] digit;
  } digit_t;

  // Classified character as it travels through the queue
  typedef struct packed {
    logic       delim;
    logic       bad;
    logic [5:0] digit;
    logic       last;
  } q_item_t;

  typedef struct packed {
    logic    push;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // base64url character to digit; non-digits flag bad and read as 0
  function automatic digit_t decode_char(input logic [7:0] c);
    digit_t r;
    r.bad   = 1'b0;
    r.digit = '0;
    priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r.digit = 6'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r.digit = 6'(c - CH_LOWER_A) + DIG_LOWER_BASE;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      r.digit = 6'(c - CH_ZERO) + DIG_NUM_BASE;
    end else if (c == CH_DASH) begin
      r.digit = DIG_DASH;
    end else if (c == CH_UNDER) begin
      r.digit = DIG_UNDER;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/b64d_if.sv
// Valid/ready channel interfaces for the character and result streams.
// Standalone; field widths follow the decoder's item definitions.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  word_kind;
  logic [31:0] word_value;
  logic [31:0] pixel_index;
  logic [1:0]  status;
  logic        final_flag;

  modport source (output valid, output word_kind, output word_value, output pixel_index,
                  output status, output final_flag, input ready);
  modport sink   (input valid, input word_kind, input word_value, input pixel_index,
                  input status, input final_flag, output ready);
endinterface

// File: rtl/core/b64d_front.sv
// Front end: delimiter register, character classification, queue push.
// Depends on b64d_pkg and b64d_char_if.
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  b64d_char_if.sink           chars,
  input  logic                q_full,
  output b64d_pkg::q_push_t   q_push
);
  import b64d_pkg::*;

  logic [7:0] delimiter_char;
  digit_t     dig;

  // Delimiter register, comma after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= CH_COMMA;
    end else if (cfg_we) begin
      delimiter_char <= cfg_wdata;
    end
  end

  // Classify the item; delimiter test wins over the digit map
  always_comb begin
    dig                = decode_char(chars.char_code);
    chars.ready        = !q_full;
    q_push.push        = chars.valid && !q_full;
    q_push.item.delim  = (chars.char_code == delimiter_char);
    q_push.item.bad    = dig.bad;
    q_push.item.digit  = dig.digit;
    q_push.item.last   = chars.end_of_text;
  end

endmodule

// File: rtl/core/b64d_fifo.sv
// Short queue of classified items between front and back.
// Depends on b64d_pkg.
module b64d_fifo (
  input  logic               clk,
  input  logic               rst,
  input  b64d_pkg::q_push_t  q_push,
  output logic               q_full,
  output b64d_pkg::q_head_t  q_head,
  input  logic               q_pop
);
  import b64d_pkg::*;

  q_item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign q_full       = (count == Q_CNT_W'(Q_DEPTH));
  assign q_head.valid = (count != '0);
  assign q_head.item  = slots[rd_ptr];
  assign do_push      = q_push.push && !q_full;
  assign do_pop       = q_pop && q_head.valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/b64d_back.sv
// Back end: word accumulation, header/pixel sequencing, end status, output register.
// Depends on b64d_pkg and b64d_result_if.
module b64d_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  b64d_pkg::q_head_t  q_head,
  output logic               q_pop,
  b64d_result_if.source      results
);
  import b64d_pkg::*;

  back_state_t            state, state_next;
  logic [VALUE_BITS-1:0]  word_accum, word_accum_next;
  logic                   word_open, word_open_next;
  words_seen_t            words_seen, words_seen_next;
  logic [31:0]            image_width, image_width_next;
  logic [31:0]            image_height, image_height_next;
  logic [32:0]            pixels_seen, pixels_seen_next;
  status_t                error_code, error_code_next;
  logic [63:0]            area;

  logic                   out_valid, out_valid_next;
  word_kind_t             out_kind, out_kind_next;
  logic [31:0]            out_value, out_value_next;
  logic [31:0]            out_index, out_index_next;
  status_t                out_status, out_status_next;
  logic                   out_final, out_final_next;

  logic                   fin, acc, st_emit, word_emit, need_out, out_free, go, ovf;
  logic [63:0]            accum_ext;
  status_t                err_tmp;

  assign results.valid       = out_valid;
  assign results.word_kind   = out_kind;
  assign results.word_value  = out_value;
  assign results.pixel_index = out_index;
  assign results.status      = out_status;
  assign results.final_flag  = out_final;

  assign accum_ext = 64'(word_accum);
  assign ovf       = (word_accum[VALUE_BITS-1 -: 6] != '0);
  assign out_free  = !out_valid || results.ready;

  // Image area, registered; settles in the wait step before the status
  always_ff @(posedge clk) begin
    area <= 64'(image_width) * 64'(image_height);
  end

  // Sequencer and parse state update
  always_comb begin
    state_next        = state;
    word_accum_next   = word_accum;
    word_open_next    = word_open;
    words_seen_next   = words_seen;
    image_width_next  = image_width;
    image_height_next = image_height;
    pixels_seen_next  = pixels_seen;
    error_code_next   = error_code;
    out_kind_next     = out_kind;
    out_value_next    = out_value;
    out_index_next    = out_index;
    out_status_next   = out_status;
    out_final_next    = out_final;
    err_tmp           = error_code;
    fin               = 1'b0;
    acc               = 1'b0;
    st_emit           = 1'b0;

    unique case (state)
      B_CHAR: begin
        fin = q_head.valid && q_head.item.delim;
        acc = q_head.valid && !q_head.item.delim;
      end
      B_FINISH: fin = 1'b1;
      B_WAIT:   ;
      B_STATUS: st_emit = 1'b1;
      default:  ;
    endcase

    word_emit = fin && word_open && (error_code == ST_OK);
    need_out  = word_emit || st_emit;
    go        = ((state != B_CHAR) || q_head.valid) && (!need_out || out_free);
    q_pop     = go && (state == B_CHAR);

    // Output register drains when taken, loads when a result is made
    out_valid_next = out_valid && !results.ready;
    if (go && need_out) out_valid_next = 1'b1;

    if (go) begin
      // Digit: shift in, or saturate on overflow
      if (acc) begin
        if (q_head.item.bad && err_tmp == ST_OK) err_tmp = ST_BAD_CHAR;
        if (ovf) begin
          if (err_tmp == ST_OK) err_tmp = ST_OVERFLOW;
          word_accum_next = '1;
        end else begin
          word_accum_next = {word_accum[VALUE_BITS-7:0], q_head.item.digit};
        end
        error_code_next = err_tmp;
        word_open_next  = 1'b1;
      end

      // Close an open word; emit only while no error is set
      if (fin && word_open) begin
        if (word_emit) begin
          out_value_next  = accum_ext[31:0];
          out_index_next  = '0;
          out_status_next = ST_OK;
          out_final_next  = 1'b0;
          unique case (words_seen)
            WS_WIDTH: begin
              image_width_next = accum_ext[31:0];
              out_kind_next    = KIND_WIDTH;
              words_seen_next  = WS_HEIGHT;
            end
            WS_HEIGHT: begin
              image_height_next = accum_ext[31:0];
              out_kind_next     = KIND_HEIGHT;
              words_seen_next   = WS_PIXELS;
            end
            default: begin
              out_kind_next  = KIND_PIXEL;
              out_index_next = pixels_seen[31:0];
              if (pixels_seen != '1) pixels_seen_next = pixels_seen + 1'b1;
            end
          endcase
        end
        word_accum_next = '0;
        word_open_next  = 1'b0;
      end

      // End status, then parse state back to reset values
      if (st_emit) begin
        out_kind_next  = KIND_END;
        out_value_next = '0;
        out_index_next = '0;
        out_final_next = 1'b1;
        if (error_code != ST_OK) begin
          out_status_next = error_code;
        end else if (words_seen != WS_PIXELS || pixels_seen == '1 ||
                     64'(pixels_seen) != area) begin
          out_status_next = ST_MISMATCH;
        end else begin
          out_status_next = ST_OK;
        end
        word_accum_next   = '0;
        word_open_next    = 1'b0;
        words_seen_next   = WS_WIDTH;
        image_width_next  = '0;
        image_height_next = '0;
        pixels_seen_next  = '0;
        error_code_next   = ST_OK;
      end

      unique case (state)
        B_CHAR:   state_next = q_head.item.last ? B_FINISH : B_CHAR;
        B_FINISH: state_next = B_WAIT;
        B_WAIT:   state_next = B_STATUS;
        B_STATUS: state_next = B_CHAR;
        default:  state_next = B_CHAR;
      endcase
    end
  end

  // Control and parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_CHAR;
      word_accum   <= '0;
      word_open    <= 1'b0;
      words_seen   <= WS_WIDTH;
      image_width  <= '0;
      image_height <= '0;
      pixels_seen  <= '0;
      error_code   <= ST_OK;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      word_accum   <= word_accum_next;
      word_open    <= word_open_next;
      words_seen   <= words_seen_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      pixels_seen  <= pixels_seen_next;
      error_code   <= error_code_next;
      out_valid    <= out_valid_next;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_kind   <= out_kind_next;
    out_value  <= out_value_next;
    out_index  <= out_index_next;
    out_status <= out_status_next;
    out_final  <= out_final_next;
  end

endmodule

// File: rtl/core/delimited_base64_image_stream_decoder_unit.sv
// Top level of the delimited base64url image word decoder.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_fifo, b64d_back.
//
//   port      | dir | handshake       | carries
//   ----------+-----+-----------------+-----------------------------------------------
//   chars     | in  | valid/ready     | char_code, end_of_text
//   results   | out | valid/ready     | word_kind, word_value, pixel_index, status, final_flag
//   cfg_we    | in  | write strobe    | cfg_wdata -> delimiter character
//
// A character that does not end the text is handled in the char state alone, so items
// stream at one per cycle while the queue holds items and the result register drains.
// The character marked as the end of text passes through four states: char, word close, a wait
// for the registered width*height product, then the status result.
// Synchronous reset sets the delimiter to comma and clears all parse state.
// A two-entry queue lets the input keep flowing while the result side stalls.
module delimited_base64_image_stream_decoder_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  b64d_char_if.sink     chars,
  b64d_result_if.source results
);
  import b64d_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chars     (chars),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  b64d_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  b64d_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule
